FILE: rtl/lirs_pkg.sv
// ============================================================================
// lirs_pkg
// Shared types and constants for the three-axis linear interpolation resampler.
// ============================================================================
package lirs_pkg;

    localparam int MAX_OUTPUTS_DEF = 64;

    localparam int SAMPLE_W = 24;   // sample and result values
    localparam int STEP_W   = 24;   // step registers
    localparam int GAP_W    = 33;   // relative time gap
    localparam int D_W      = 35;   // signed offset from the previous sample
    localparam int MUL_W    = 25;   // signed multiplier operands
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 60;   // interpolation numerator
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [PADDR_W-1:0] ADDR_INPUT_STEP  = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_OUTPUT_STEP = 3'h4;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd10486;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 24'h80_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic                       in_window;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_x;
        logic signed [SAMPLE_W-1:0] out_y;
        logic signed [SAMPLE_W-1:0] out_z;
        logic                       last_of_run;
        logic                       overrun;
    } t_out_item;

    typedef enum logic [1:0] {
        MUL_A_IST   = 2'd0,
        MUL_DIFF_LO = 2'd1,
        MUL_DIFF_HI = 2'd2
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD    = 2'd2,
        ACC_ADD_HI = 2'd3
    } t_acc_op;

    typedef enum logic {
        DIV_TIME  = 1'b0,
        DIV_VALUE = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic              load_in;
        logic              gap_add;
        logic              div_start;
        t_div_sel          div_sel;
        logic              take_n;
        logic              pt_step;
        logic              d_load;
        logic              mul_en;
        t_mul_op           mul_op;
        t_acc_op           acc_op;
        logic              sat_store;
        logic              emit;
        logic              commit;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic gap_zero;
        logic div_done;
        logic m_zero;
        logic last_pt;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/lirs_div.sv
// ============================================================================
// lirs_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ============================================================================
module lirs_div #(
    parameter int DIVIDEND_W = 60,
    parameter int DIVISOR_W  = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder,
    output logic                  o_done
);
    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fits;

    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_trial = w_shift - {1'b0, r_dvs};
        w_fits  = (w_shift >= {1'b0, r_dvs});
        n_rem   = w_fits ? w_trial[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
        n_quo   = {r_quo[DIVIDEND_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == CNT_W'(DIVIDEND_W - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

FILE: rtl/lirs_datapath.sv
// ============================================================================
// lirs_datapath
// Sample and time state, shared multiplier, divider and output register.
// ============================================================================
module lirs_datapath #(
    parameter int MAX_OUTPUTS = lirs_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lirs_pkg::t_in_item                  i_in_data,
    input  logic [lirs_pkg::STEP_W-1:0]         i_input_step,
    input  logic [lirs_pkg::STEP_W-1:0]         i_output_step,
    input  lirs_pkg::t_cmd                      i_cmd,
    output lirs_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    output lirs_pkg::t_out_item                 o_out_data,
    input  logic                                i_out_stall
);
    import lirs_pkg::*;

    localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);

    logic [SAMPLE_W-1:0] r_prev [AXES];
    logic [SAMPLE_W-1:0] r_cur  [AXES];
    logic [SAMPLE_W-1:0] r_res  [AXES];
    logic                r_win;
    logic                r_have_prev;
    logic [GAP_W-1:0]    r_gap;
    logic [GAP_W-1:0]    r_pt;
    logic [D_W-1:0]      r_d;
    logic [CNT_W-1:0]    r_k;
    logic [CNT_W-1:0]    r_m;
    logic                r_over;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic                r_neg;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [STEP_W-1:0]   w_ist;
    logic [STEP_W-1:0]   w_ost;
    logic signed [MUL_W-1:0] w_op_a;
    logic signed [MUL_W-1:0] w_op_b;
    logic signed [MUL_W-1:0] w_diff;
    logic [ACC_W-1:0]    w_prod_ext;
    logic [ACC_W-1:0]    w_mag;
    logic [ACC_W-1:0]    w_dividend;
    logic [STEP_W-1:0]   w_divisor;
    logic [ACC_W-1:0]    w_quo;
    logic [STEP_W-1:0]   w_rem;
    logic                w_div_done;
    logic                w_pos_ovf;
    logic                w_neg_ovf;
    logic [SAMPLE_W-1:0] w_sat;
    logic                w_n_over;
    logic                w_out_free;
    logic                w_last_pt;

    // a zero step acts as one
    assign w_ist = (i_input_step  == '0) ? STEP_W'(1) : i_input_step;
    assign w_ost = (i_output_step == '0) ? STEP_W'(1) : i_output_step;

    assign w_diff = $signed({r_cur[i_cmd.axis][SAMPLE_W-1], r_cur[i_cmd.axis]})
                  - $signed({r_prev[i_cmd.axis][SAMPLE_W-1], r_prev[i_cmd.axis]});

    always_comb begin
        case (i_cmd.mul_op)
            MUL_A_IST: begin
                w_op_a = $signed({r_prev[i_cmd.axis][SAMPLE_W-1], r_prev[i_cmd.axis]});
                w_op_b = $signed({1'b0, w_ist});
            end
            MUL_DIFF_LO: begin
                w_op_a = w_diff;
                w_op_b = $signed({1'b0, r_d[STEP_W-1:0]});
            end
            MUL_DIFF_HI: begin
                w_op_a = w_diff;
                w_op_b = $signed({{(MUL_W-(D_W-STEP_W)){r_d[D_W-1]}}, r_d[D_W-1:STEP_W]});
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_mag      = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;

    assign w_dividend = (i_cmd.div_sel == DIV_TIME) ?
                        {{(ACC_W-GAP_W){1'b0}}, r_gap - 1'b1} : w_mag;
    assign w_divisor  = (i_cmd.div_sel == DIV_TIME) ? w_ost : w_ist;

    lirs_div #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (STEP_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_done      (w_div_done)
    );

    // truncated quotient, clamped to the signed 24-bit range
    always_comb begin
        w_pos_ovf = |w_quo[ACC_W-1:SAMPLE_W-1];
        w_neg_ovf = (|w_quo[ACC_W-1:SAMPLE_W])
                  || (w_quo[SAMPLE_W-1] && (|w_quo[SAMPLE_W-2:0]));
        if (r_neg) begin
            w_sat = w_neg_ovf ? SAT_MIN : (~w_quo[SAMPLE_W-1:0] + 1'b1);
        end else begin
            w_sat = w_pos_ovf ? SAT_MAX : w_quo[SAMPLE_W-1:0];
        end
    end

    assign w_n_over   = (w_quo > ACC_W'(MAX_OUTPUTS));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_pt  = ((r_k + CNT_W'(1)) == r_m);

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_prev[i] <= '0;
            end
            r_have_prev <= 1'b0;
            r_gap       <= '0;
            r_k         <= '0;
            r_m         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                for (int i = 0; i < AXES; i++) begin
                    r_prev[i] <= r_cur[i];
                end
                r_have_prev <= 1'b1;
            end
            if (i_cmd.gap_add) begin
                r_gap <= r_gap + {{(GAP_W-STEP_W){1'b0}}, w_ist};
            end else if (i_cmd.take_n) begin
                r_gap <= {{(GAP_W-STEP_W){1'b0}}, w_rem} + 1'b1;
            end
            if (i_cmd.take_n) begin
                r_k <= '0;
                r_m <= w_n_over ? CNT_W'(MAX_OUTPUTS) : w_quo[CNT_W-1:0];
            end else if (i_cmd.emit) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur[0] <= i_in_data.sample_x;
            r_cur[1] <= i_in_data.sample_y;
            r_cur[2] <= i_in_data.sample_z;
            r_win    <= i_in_data.in_window;
        end
        if (i_cmd.take_n) begin
            r_pt   <= r_gap;
            r_over <= w_n_over;
        end else if (i_cmd.pt_step) begin
            r_pt <= r_pt - {{(GAP_W-STEP_W){1'b0}}, w_ost};
        end
        if (i_cmd.d_load) begin
            r_d <= {{(D_W-STEP_W){1'b0}}, w_ist} - {{(D_W-GAP_W){1'b0}}, r_pt};
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_op_a * w_op_b;
        end
        case (i_cmd.acc_op)
            ACC_LOAD:   r_acc <= w_prod_ext;
            ACC_ADD:    r_acc <= r_acc + w_prod_ext;
            ACC_ADD_HI: r_acc <= r_acc + {w_prod_ext[ACC_W-STEP_W-1:0], {STEP_W{1'b0}}};
            default:    r_acc <= r_acc;
        endcase
        if (i_cmd.div_start) begin
            r_neg <= r_acc[ACC_W-1];
        end
        if (i_cmd.sat_store) begin
            r_res[i_cmd.axis] <= w_sat;
        end
        if (i_cmd.emit) begin
            r_out.out_x       <= r_res[0];
            r_out.out_y       <= r_res[1];
            r_out.out_z       <= r_res[2];
            r_out.last_of_run <= w_last_pt;
            r_out.overrun     <= r_over;
        end
    end

    assign o_status.run      = r_win && r_have_prev;
    assign o_status.gap_zero = (r_gap == '0);
    assign o_status.div_done = w_div_done;
    assign o_status.m_zero   = (r_m == '0);
    assign o_status.last_pt  = w_last_pt;
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over one not yet transferred");

    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_n |=> (r_gap != '0))
        else $error("gap left at zero after point count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k <= r_m) && (r_m <= CNT_W'(MAX_OUTPUTS)))
        else $error("point counter beyond run length");
`endif

endmodule

FILE: rtl/lirs_ctrl.sv
// ============================================================================
// lirs_ctrl
// Sequencer: time advance, point count, per-axis multiply/divide, emission.
// ============================================================================
module lirs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lirs_pkg::t_status i_status,
    output lirs_pkg::t_cmd    o_cmd
);
    import lirs_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_GAP    = 16'h0002,
        S_NDIV   = 16'h0004,
        S_NWAIT  = 16'h0008,
        S_CHK    = 16'h0010,
        S_STEP   = 16'h0020,
        S_DSET   = 16'h0040,
        S_MUL0   = 16'h0080,
        S_MUL1   = 16'h0100,
        S_MUL2   = 16'h0200,
        S_ACC    = 16'h0400,
        S_DIVS   = 16'h0800,
        S_DIVW   = 16'h1000,
        S_SAT    = 16'h2000,
        S_EMIT   = 16'h4000,
        S_FINISH = 16'h8000
    } t_state;

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_GAP;
                end
            end
            S_GAP: begin
                o_cmd.gap_add = i_status.run;
                n_state       = i_status.run ? S_NDIV : S_FINISH;
            end
            S_NDIV: begin
                if (i_status.gap_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_TIME;
                    n_state         = S_NWAIT;
                end
            end
            S_NWAIT: begin
                o_cmd.div_sel = DIV_TIME;
                if (i_status.div_done) begin
                    o_cmd.take_n = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_status.m_zero ? S_FINISH : S_STEP;
            end
            S_STEP: begin
                o_cmd.pt_step = 1'b1;
                n_axis        = '0;
                n_state       = S_DSET;
            end
            S_DSET: begin
                o_cmd.d_load = 1'b1;
                n_state      = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_A_IST;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_DIFF_LO;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_DIFF_HI;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_op = ACC_ADD_HI;
                n_state      = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VALUE;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                o_cmd.div_sel = DIV_VALUE;
                if (i_status.div_done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.sat_store = 1'b1;
                if (r_axis == AXIS_W'(AXES - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_MUL0;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_pt ? S_FINISH : S_STEP;
                end
            end
            S_FINISH: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_GAP))
        else $error("accepted sample did not start a run");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !i_status.out_free) |=> (r_state == S_EMIT))
        else $error("left emit state with output slot full");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVW) && !i_status.div_done) |=> (r_state == S_DIVW))
        else $error("left divide wait before quotient ready");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT) |-> (r_axis < AXIS_W'(AXES)))
        else $error("axis index out of range");
`endif

endmodule

FILE: rtl/linear_interp_resampler_3axis_core.sv
// ============================================================================
// linear_interp_resampler_3axis_core
// Three-axis linear interpolation resampler with an APB step-register port.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//  cfg     | input     | APB psel/penable/pready | paddr, pwdata, prdata
//
//  An in-window sample with m points uses the 60-step shared restoring
//  divider once for the point count and once per axis per point, plus
//  multiply/accumulate/start/store states per axis and step/offset/emit
//  states per point.
//  Reset clears sample history and time gap and loads both steps with 10486;
//  no clearing pass.
//  Output stall holds the sequencer before the next point is loaded; the
//  input is stalled for the whole of each sample's run.
//
module linear_interp_resampler_3axis_core #(
    parameter int MAX_OUTPUTS = lirs_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lirs_pkg::t_in_item             i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lirs_pkg::t_out_item            o_out_data,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lirs_pkg::PADDR_W-1:0]   paddr,
    input  logic [lirs_pkg::PDATA_W-1:0]   pwdata,
    output logic [lirs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import lirs_pkg::*;

    logic [STEP_W-1:0] r_input_step;
    logic [STEP_W-1:0] r_output_step;
    logic              w_cfg_wr;
    t_cmd              w_cmd;
    t_status           w_status;

    // Step registers: written on the access phase of an APB transfer.
    // Steps are to be changed only while the block is idle; the block does not enforce this.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_step  <= STEP_RESET;
            r_output_step <= STEP_RESET;
        end else if (w_cfg_wr) begin
            case (paddr)
                ADDR_INPUT_STEP:  r_input_step  <= pwdata[STEP_W-1:0];
                ADDR_OUTPUT_STEP: r_output_step <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_INPUT_STEP:  prdata = {{(PDATA_W-STEP_W){1'b0}}, r_input_step};
            ADDR_OUTPUT_STEP: prdata = {{(PDATA_W-STEP_W){1'b0}}, r_output_step};
            default:          prdata = '0;
        endcase
    end

    // Sequencer: walks each in-window sample through the time advance, the point
    // count division and, per point, three axis evaluations.
    lirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: sample history, time gap, shared multiplier and divider,
    // and the output register that decouples the result transfer.
    lirs_datapath #(
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_input_step  (r_input_step),
        .i_output_step (r_output_step),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the three-axis linear interpolation resampler.
// Random and directed samples go in over the valid/stall channel. Each
// accepted sample is run through a cycle-free model of the resampler, which
// queues the points that the block must emit. Every result transfer is then
// compared field by field with the oldest queued point. The step registers
// are reprogrammed over APB between phases, once the block is idle.
// ============================================================================
module tb_top;

    import lirs_pkg::*;

    // run control
    localparam int unsigned CYCLE_LIMIT      = 12_000_000;
    localparam int unsigned SETTLE_CYCLES    = 150;
    localparam int unsigned TAIL_CYCLES      = 300;
    localparam int unsigned LONG_HOLD_AFTER  = 150;  // results taken before the long hold
    localparam int unsigned LONG_HOLD_CYCLES = 500;
    localparam int unsigned WINDOW_PCT       = 85;

    // ------------------------------------------------------------------------
    // Point tracker: holds its own copy of the step registers, the previous
    // sample and the time gap, and queues the points each sample produces.
    // ------------------------------------------------------------------------
    class resample_tracker;
        logic        [STEP_W-1:0]   input_step;
        logic        [STEP_W-1:0]   output_step;
        logic signed [SAMPLE_W-1:0] last_x, last_y, last_z;
        bit                         seen_one;
        logic        [GAP_W-1:0]    gap;
        t_out_item                  expected_points[$];
        int unsigned                mismatches;

        function new();
            input_step  = STEP_RESET;
            output_step = STEP_RESET;
            last_x      = '0;
            last_y      = '0;
            last_z      = '0;
            seen_one    = 1'b0;
            gap         = '0;
            mismatches  = 0;
        endfunction

        function void write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
            case (addr)
                ADDR_INPUT_STEP:  input_step  = data[STEP_W-1:0];
                ADDR_OUTPUT_STEP: output_step = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_points.size();
        endfunction

        // (a*span + (b-a)*d) / span, truncated toward zero, then clamped
        function logic [SAMPLE_W-1:0] interp_axis(longint a, longint b, longint d,
                                                  longint span);
            longint q;
            q = (a * span + (b - a) * d) / span;
            if (q > longint'($signed(SAT_MAX)))
                return SAT_MAX;
            if (q < longint'($signed(SAT_MIN)))
                return SAT_MIN;
            return q[SAMPLE_W-1:0];
        endfunction

        function void take_sample(t_in_item s);
            longint unsigned ist, ost, g, n, m;
            longint          d;
            bit              over;
            t_out_item       pt;
            if (s.in_window && seen_one) begin
                // a zero step behaves as one unit
                ist  = (input_step  == '0) ? 1 : longint'(input_step);
                ost  = (output_step == '0) ? 1 : longint'(output_step);
                gap  = GAP_W'(longint'(gap) + ist);
                g    = longint'(gap);
                n    = (g > 0) ? (g - 1) / ost : 0;
                over = n > MAX_OUTPUTS_DEF;
                m    = over ? MAX_OUTPUTS_DEF : n;
                for (longint unsigned k = 0; k < m; k++) begin
                    g  = g - ost;
                    // negative d means extrapolation behind the previous sample
                    d  = longint'(ist) - longint'(g);
                    pt.out_x       = interp_axis(longint'($signed(last_x)),
                                                 longint'($signed(s.sample_x)), d, ist);
                    pt.out_y       = interp_axis(longint'($signed(last_y)),
                                                 longint'($signed(s.sample_y)), d, ist);
                    pt.out_z       = interp_axis(longint'($signed(last_z)),
                                                 longint'($signed(s.sample_z)), d, ist);
                    pt.last_of_run = (k + 1 == m);
                    pt.overrun     = over;
                    expected_points.insert(expected_points.size(), pt);
                end
                // dropped points still consume time
                gap = GAP_W'(longint'(gap) - n * ost);
            end
            last_x   = s.sample_x;
            last_y   = s.sample_y;
            last_z   = s.sample_z;
            seen_one = 1'b1;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_point(t_out_item got);
            t_out_item want;
            if (expected_points.size() == 0) begin
                $error("result transfer with no point pending: %p", got);
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            compare_field("out_x", longint'($signed(want.out_x)), longint'($signed(got.out_x)));
            compare_field("out_y", longint'($signed(want.out_y)), longint'($signed(got.out_y)));
            compare_field("out_z", longint'($signed(want.out_z)), longint'($signed(got.out_z)));
            compare_field("last_of_run", longint'(want.last_of_run),
                          longint'(got.last_of_run));
            compare_field("overrun", longint'(want.overrun), longint'(got.overrun));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 o_in_stall;
    t_in_item             in_data;
    logic                 o_out_valid;
    logic                 out_stall;
    t_out_item            o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    resample_tracker      tracker = new();
    int unsigned          idle_pct;    // percent chance of an input gap or stall burst
    bit                   quiet_tail;  // no idling at all in the last phase

    linear_interp_resampler_3axis_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------------
    function automatic t_in_item sample_of(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
                                           logic [SAMPLE_W-1:0] z, logic w);
        t_in_item s;
        s.sample_x  = x;
        s.sample_y  = y;
        s.sample_z  = z;
        s.in_window = w;
        return s;
    endfunction

    function automatic t_in_item random_sample();
        logic [31:0] bx, by, bz;
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        return sample_of(bx[SAMPLE_W-1:0], by[SAMPLE_W-1:0], bz[SAMPLE_W-1:0],
                         $urandom_range(0, 99) < WINDOW_PCT);
    endfunction

    // Offers one sample and returns at the edge where it is transferred.
    // Valid stays high on return so that back-to-back samples need no dip.
    task automatic offer_sample(input t_in_item s);
        if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_sample(s);
    endtask

    // Drop valid and let the block empty. A sample that yields no point
    // leaves the block busy for a while after the last result, hence the pause.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase held until pready, then the
    // bus returns to idle
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_register(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_steps(input logic [PDATA_W-1:0] ist, input logic [PDATA_W-1:0] ost);
        wait_idle();
        apb_write(ADDR_INPUT_STEP, ist);
        apb_write(ADDR_OUTPUT_STEP, ost);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold so the block backs
    // up and stalls its sample input while samples keep being offered.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned points_taken;
        bit          long_hold_done;
        stall_left     = 0;
        points_taken   = 0;
        long_hold_done = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !out_stall) begin
                tracker.check_point(o_out_data);
                points_taken++;
            end
            if (!long_hold_done && !quiet_tail && points_taken >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Hang guard
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned    items;
        logic [31:0]    ist_word, ost_word;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        idle_pct   = 25;
        quiet_tail = 1'b0;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset steps: first and third samples give nothing, the out-of-window
        // second only replaces the history, the fourth gives one full-scale point.
        offer_sample(sample_of(SAT_MAX, SAT_MIN, 24'd0, 1'b1));
        offer_sample(sample_of(24'hFF_FFFF, 24'd1, 24'd12345, 1'b0));
        offer_sample(sample_of(SAT_MIN, SAT_MAX, 24'hFF_FFFF, 1'b1));
        offer_sample(sample_of(SAT_MAX, SAT_MAX, SAT_MIN, 1'b1));

        // Zero steps act as one unit; the gap left over gives far more than
        // MAX_OUTPUTS points, so the first run overruns.
        set_steps(32'h0, 32'h0);
        offer_sample(sample_of(24'd1000, -24'sd1000, 24'd0, 1'b1));
        offer_sample(sample_of(24'd77, 24'd0, -24'sd77, 1'b1));

        // All-ones writes: upper data bits ignored, steps at full scale
        set_steps(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_sample(sample_of(SAT_MIN, 24'd7, SAT_MAX, 1'b1));
        offer_sample(sample_of(SAT_MAX, -24'sd7, SAT_MIN, 1'b1));

        // Build a gap well above the later output step, then shrink the
        // output step: the early points extrapolate past the rails.
        set_steps(32'h0080_0000, 32'hFFFF_FFFF);
        offer_sample(sample_of(SAT_MAX, SAT_MIN, 24'd0, 1'b1));
        set_steps(32'h0080_0000, 32'h0008_0000);
        offer_sample(sample_of(SAT_MIN, SAT_MAX, 24'd100, 1'b1));
        offer_sample(sample_of(24'd0, 24'd0, 24'd0, 1'b1));

        // Tiny input step against a huge output step: no points at all
        set_steps(32'h1, 32'h00FF_FFFF);
        offer_sample(sample_of(24'd5, 24'd6, 24'd7, 1'b1));
        offer_sample(sample_of(24'd8, 24'd9, 24'd10, 1'b1));

        // Random phases. Mostly moderate step ratios (a few points per
        // sample); one phase of full-range steps and one of tiny steps.
        for (int ph = 0; ph < 9; ph++) begin
            ist_word = $urandom_range(2000, 40000);
            ost_word = ist_word * $urandom_range(25, 300) / 100;
            items    = 25;
            idle_pct = 25 * $urandom_range(0, 2);
            if (ph == 6) begin
                ist_word = $urandom;
                ost_word = $urandom;
                items    = 4;
            end else if (ph == 7) begin
                ist_word = $urandom_range(0, 3);
                ost_word = $urandom_range(0, 3);
                items    = 15;
            end else if (ph == 8) begin
                items = 30;
            end
            set_steps(ist_word, ost_word);
            if (ph == 8) begin
                quiet_tail = 1'b1;
                idle_pct   = 0;
            end
            repeat (items) offer_sample(random_sample());
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
